FILE: design/sorted_key_index_table_defines.svh
// ---------------------------------------------------------------------------
// Sorted key index table: assertion macros
// Shared concurrent assertion forms for the sorted key index table.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_INDEX_TABLE_DEFINES_SVH
`define SORTED_KEY_INDEX_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SKIT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define SKIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: design/skit_pkg.sv
// ---------------------------------------------------------------------------
// Sorted key index table package
// Result codes, controller states and the controller/datapath interface.
// ---------------------------------------------------------------------------
package skit_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Input action codes
    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_INSERT = 1'b1
    } action_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_COMPARE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_REPORT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;        // capture item, open search window
        logic    probe_rd;    // read table at search midpoint
        logic    narrow;      // shrink search window after a miss
        logic    shift_init;  // start shift at the entry count
        logic    shift_rd;    // read entry below the shift pointer
        logic    shift_wr;    // write it one place up, step pointer down
        logic    place;       // write the new key at the insertion point
        logic    set_result;  // latch a result code
        status_t res_code;
        logic    res_use_slot;
        logic    report;      // move result into the output register
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        action_t action;
        logic    search_done; // search window is empty
        logic    hit;         // read key equals search key
        logic    full;        // table holds its maximum count
        logic    shift_done;  // shift pointer reached insertion point
        logic    out_free;    // output register can take a result
    } dp_status_t;

endpackage

FILE: design/skit_datapath.sv
// ---------------------------------------------------------------------------
// Sorted key index table datapath
// Table memory, search window, shift pointer, entry count and output register.
// ---------------------------------------------------------------------------
module skit_datapath
    import skit_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_action,
    input  logic [15:0] in_key,
    input  dp_cmd_t     cmd,
    output dp_status_t  sts,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_status,
    output logic [3:0]  out_slot,
    output logic [4:0]  out_entries
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MEM_W = KEY_BITS + IDX_W;

    // Table memory: key in the upper bits, paired slot in the lower bits
    logic [MEM_W-1:0] table_mem [TABLE_DEPTH];
    logic [MEM_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    hi_reg;
    logic [CNT_W-1:0]    shift_reg;
    logic [KEY_BITS-1:0] key_reg;
    action_t             action_reg;
    status_t             res_status_reg;
    logic [IDX_W-1:0]    res_slot_reg;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [3:0]          out_slot_reg;
    logic [4:0]          out_entries_reg;

    logic [CNT_W-1:0]    mid;
    logic [CNT_W-1:0]    shift_m1;
    logic [KEY_BITS-1:0] rd_key;
    logic [IDX_W-1:0]    rd_slot;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [MEM_W-1:0]    wr_data;
    logic                wr_en;

    // Derive midpoint, shift source and read fields
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign shift_m1 = shift_reg - CNT_W'(1);
    assign rd_key   = rd_data_reg[MEM_W-1 -: KEY_BITS];
    assign rd_slot  = rd_data_reg[IDX_W-1:0];

    // Select memory addresses and write data
    assign rd_addr = cmd.probe_rd ? mid[IDX_W-1:0] : shift_m1[IDX_W-1:0];
    assign wr_en   = cmd.shift_wr | cmd.place;
    assign wr_addr = cmd.shift_wr ? shift_reg[IDX_W-1:0] : lo_reg[IDX_W-1:0];
    assign wr_data = cmd.shift_wr ? rd_data_reg : {key_reg, count_reg[IDX_W-1:0]};

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (cmd.probe_rd || cmd.shift_rd)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // Search window, shift pointer, item capture and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= KEY_BITS'(in_key);
            action_reg <= action_t'(in_action);
            lo_reg     <= '0;
            hi_reg     <= count_reg;
        end
        else if (cmd.narrow)
        begin
            if (key_reg > rd_key)
            begin
                lo_reg <= mid + CNT_W'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end

        if (cmd.shift_init)
        begin
            shift_reg <= count_reg;
        end
        else if (cmd.shift_wr)
        begin
            shift_reg <= shift_m1;
        end

        if (cmd.place)
        begin
            res_status_reg <= ST_OK;
            res_slot_reg   <= count_reg[IDX_W-1:0];
        end
        else if (cmd.set_result)
        begin
            res_status_reg <= cmd.res_code;
            res_slot_reg   <= cmd.res_use_slot ? rd_slot : '0;
        end
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.place)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Output register: load on report, drop valid after a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.report)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            out_status_reg  <= res_status_reg;
            out_slot_reg    <= 4'(res_slot_reg);
            out_entries_reg <= 5'(count_reg);
        end
    end

    // Status toward the controller
    assign sts.action      = action_reg;
    assign sts.search_done = (lo_reg >= hi_reg);
    assign sts.hit         = (rd_key == key_reg);
    assign sts.full        = (count_reg == CNT_W'(TABLE_DEPTH));
    assign sts.shift_done  = (shift_reg == lo_reg);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_slot    = out_slot_reg;
    assign out_entries = out_entries_reg;

endmodule

FILE: design/skit_controller.sv
// ---------------------------------------------------------------------------
// Sorted key index table controller
// Sequences binary search, insertion shift and result report.
// ---------------------------------------------------------------------------
module skit_controller
    import skit_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_code = ST_OK;
        in_stall   = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (sts.search_done)
                begin
                    if (sts.action == ACT_LOOKUP)
                    begin
                        cmd.set_result = 1'b1;
                        cmd.res_code   = ST_NOT_FOUND;
                        state_next     = S_REPORT;
                    end
                    else if (sts.full)
                    begin
                        cmd.set_result = 1'b1;
                        cmd.res_code   = ST_FULL;
                        state_next     = S_REPORT;
                    end
                    else
                    begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT_RD;
                    end
                end
                else
                begin
                    cmd.probe_rd = 1'b1;
                    state_next   = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                if (sts.hit)
                begin
                    cmd.set_result = 1'b1;
                    if (sts.action == ACT_LOOKUP)
                    begin
                        cmd.res_code     = ST_OK;
                        cmd.res_use_slot = 1'b1;
                    end
                    else
                    begin
                        cmd.res_code = ST_DUPLICATE;
                    end
                    state_next = S_REPORT;
                end
                else
                begin
                    cmd.narrow = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (sts.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/sorted_key_index_table.sv
// ---------------------------------------------------------------------------
// Sorted key index table
// Ascending key table with binary-search lookup and ordered insertion.
// ---------------------------------------------------------------------------
// The block takes one item at a time and gives one result per item. Each
// item runs a binary search in which each probe reads the table at the
// midpoint and then compares the key read. An insert that places a new key
// then moves every larger entry up one place, each with a read and then a
// write, and writes the new key at the insertion point. A duplicate insert
// ends like a lookup hit and an insert into a full table like a lookup
// miss. Each probe and each moved entry needs a read step and a step after
// it because the table is a single memory with one registered read port and
// one write port. The next item is taken as soon as the result sits in the
// output register, even while that result still waits to be taken.
`include "sorted_key_index_table_defines.svh"

module sorted_key_index_table
    import skit_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [15:0] key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  slot,
    output logic [4:0]  entries
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    // Sequence each item
    skit_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold table, search state and result
    skit_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_action   (action),
        .in_key      (key),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_status  (status),
        .out_slot    (slot),
        .out_entries (entries)
    );

    // Busy right after an input transfer
    `SKIT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // Never write a new key into a full table
    `SKIT_ASSERT_IMP(a_no_place_when_full, clk, rst_n, cmd.place, !sts.full)
    // Output valid rises only from a report
    `SKIT_ASSERT_IMP(a_valid_from_report, clk, rst_n, $rose(out_valid), $past(cmd.report))

endmodule

FILE: tb/sv/sorted_key_index_table_tb.sv
// ---------------------------------------------------------------------------
// Sorted key index table testbench
// Sends lookup and insert transfers to the table and checks every result,
// field by field, against a behavioral table that lives in the bench. The
// directed tests cover the empty table, ordered insertion with shifting,
// duplicates, the extreme keys and the full table. Random traffic then runs
// while the table fills and after it is full. The sender works in bursts,
// the receiver stalls on its own pattern, and one long output hold-off
// fills the block until its input stalls.
// ---------------------------------------------------------------------------
module sorted_key_index_table_tb;
    import skit_pkg::*;

    localparam int DEPTH        = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int PRINT_LIMIT  = 30;

    typedef struct packed {
        status_t     status;
        logic [3:0]  slot;
        logic [4:0]  entries;
    } table_answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [15:0] key;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [4:0]  entries;

    // Bench copy of the table contents
    logic [15:0] held_keys [DEPTH];
    logic [3:0]  held_slots [DEPTH];
    int          held_count;

    table_answer_t pending_answers [$];

    int mismatches;
    int items_sent;
    int status_seen [4];
    int idle_cycles;
    int burst_left;
    bit hold_off_request;
    bit hold_active;

    sorted_key_index_table #(
        .TABLE_DEPTH (DEPTH),
        .KEY_BITS    (16)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .slot      (slot),
        .entries   (entries)
    );

    // Free-running clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Binary search over the held keys; gives the match or insertion point
    function automatic bit locate_key(input logic [15:0] k, output int pos);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = held_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (held_keys[mid] == k)
            begin
                pos = mid;
                return 1'b1;
            end
            if (k > held_keys[mid])
                lo = mid + 1;
            else
                hi = mid;
        end
        pos = lo;
        return 1'b0;
    endfunction

    // Apply one transfer to the bench table and return the answer it gives
    function automatic table_answer_t apply_to_table(input action_t act,
                                                     input logic [15:0] k);
        table_answer_t ans;
        int            pos;
        bit            found;
        found      = locate_key(k, pos);
        ans.status = ST_OK;
        ans.slot   = '0;
        if (act == ACT_LOOKUP)
        begin
            if (found)
                ans.slot = held_slots[pos];
            else
                ans.status = ST_NOT_FOUND;
        end
        else if (found)
            ans.status = ST_DUPLICATE;
        else if (held_count >= DEPTH)
            ans.status = ST_FULL;
        else
        begin
            // shift larger keys up one place, then place the new key
            for (int i = held_count; i > pos; i--)
            begin
                held_keys[i]  = held_keys[i - 1];
                held_slots[i] = held_slots[i - 1];
            end
            held_keys[pos]  = k;
            held_slots[pos] = 4'(held_count);
            ans.slot        = 4'(held_count);
            held_count++;
        end
        ans.entries = 5'(held_count);
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    // Insert random gaps between bursts of transfers
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    // Offer one item, hold it until accepted, then record its answer
    task automatic send_item(input action_t act, input logic [15:0] k);
        table_answer_t ans;
        @(negedge clk);
        in_valid <= 1'b1;
        action   <= act;
        key      <= k;
        do
            @(posedge clk);
        while (in_stall);
        ans = apply_to_table(act, k);
        pending_answers.push_back(ans);
        status_seen[ans.status]++;
        items_sent++;
    endtask

    // Pick a key biased toward held keys and their neighbors
    task automatic send_random(input int insert_pct);
        action_t     act;
        logic [15:0] k;
        int          pick;
        act  = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_LOOKUP;
        pick = $urandom_range(99);
        if (held_count > 0 && pick < 55)
            k = held_keys[$urandom_range(held_count - 1)];
        else if (held_count > 0 && pick < 75)
            k = held_keys[$urandom_range(held_count - 1)]
                + ($urandom_range(1) ? 16'h0001 : 16'hFFFF);
        else if (pick < 80)
            k = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
        else
            k = 16'($urandom);
        send_item(act, k);
    endtask

    task automatic test_empty_table();
        pace_sender();
        send_item(ACT_LOOKUP, 16'h0000);
        pace_sender();
        send_item(ACT_LOOKUP, 16'hFFFF);
    endtask

    task automatic test_ordered_insert();
        logic [15:0] seq_keys [5];
        seq_keys = '{16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000};
        // out-of-order inserts force shifting; the last one is a duplicate
        foreach (seq_keys[i])
        begin
            pace_sender();
            send_item(ACT_INSERT, seq_keys[i]);
        end
        foreach (seq_keys[i])
        begin
            pace_sender();
            send_item(ACT_LOOKUP, seq_keys[i]);
        end
        pace_sender();
        send_item(ACT_LOOKUP, 16'h8001);
    endtask

    task automatic test_random_fill();
        for (int n = 0; n < 900; n++)
        begin
            pace_sender();
            send_random(4);
        end
    endtask

    task automatic test_full_table();
        logic [15:0] k;
        int          pos;
        while (held_count < DEPTH)
        begin
            do
                k = 16'($urandom);
            while (locate_key(k, pos));
            pace_sender();
            send_item(ACT_INSERT, k);
        end
        // new key on a full table, then a duplicate, which wins over full
        do
            k = 16'($urandom);
        while (locate_key(k, pos));
        send_item(ACT_INSERT, k);
        send_item(ACT_INSERT, held_keys[0]);
        send_item(ACT_LOOKUP, held_keys[0]);
        send_item(ACT_LOOKUP, held_keys[DEPTH - 1]);
        send_item(ACT_LOOKUP, k);
    endtask

    task automatic test_output_backpressure();
        // drop valid while waiting for the hold-off to begin
        @(negedge clk);
        in_valid <= 1'b0;
        hold_off_request = 1'b1;
        wait (hold_active);
        for (int n = 0; n < 20; n++)
            send_random(30);
        wait (!hold_active);
    endtask

    task automatic test_random_full();
        for (int n = 0; n < 1000; n++)
        begin
            pace_sender();
            send_random(30);
        end
    endtask

    // Receiver stall pattern, with one long hold-off on request
    initial
    begin : receiver_pattern
        int span;
        int stall_pct;
        out_stall   = 1'b0;
        hold_active = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_request)
            begin
                @(negedge clk);
                out_stall   <= 1'b1;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_active      = 1'b0;
                hold_off_request = 1'b0;
            end
            span = $urandom_range(8, 64);
            case ($urandom_range(2))
                0: stall_pct = 0;
                1: stall_pct = 25;
                default: stall_pct = 70;
            endcase
            repeat (span)
            begin
                @(negedge clk);
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Compare each result transfer with the oldest pending answer
    always @(posedge clk)
    begin : result_check
        table_answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("result with nothing pending, status", status, -1);
            else
            begin
                want = pending_answers.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (slot !== want.slot)
                    report_mismatch("slot", slot, want.slot);
                if (entries !== want.entries)
                    report_mismatch("entries", entries, want.entries);
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin : stall_watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("sorted_key_index_table_tb failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : run_tests
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        action           = ACT_LOOKUP;
        key              = '0;
        held_count       = 0;
        mismatches       = 0;
        items_sent       = 0;
        idle_cycles      = 0;
        burst_left       = 0;
        hold_off_request = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_ordered_insert();
        test_random_fill();
        test_full_table();
        test_output_backpressure();
        test_random_full();

        // drop valid, drain, then allow for any stray late result
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transfers: %0d ok, %0d not found, %0d duplicate, %0d full",
                 items_sent, status_seen[ST_OK], status_seen[ST_NOT_FOUND],
                 status_seen[ST_DUPLICATE], status_seen[ST_FULL]);
        $display("table filled to %0d keys; output held off %0d cycles under input load",
                 held_count, HOLD_CYCLES);
        if (mismatches == 0)
            $display("sorted_key_index_table_tb passed");
        else
            $display("sorted_key_index_table_tb failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/skit_pkg.sv
design/skit_datapath.sv
design/skit_controller.sv
design/sorted_key_index_table.sv
tb/sv/sorted_key_index_table_tb.sv
